### design/qva_pkg.sv
// Package: constants and widths for the quaternion vertical acceleration core.
`timescale 1ns / 1ps
package qva_pkg;

  localparam int ACCEL_FRAC_BITS = 13;
  localparam int QUAT_FRAC_BITS  = 30;
  localparam int Q_FRAC          = 16;

  localparam int RAW_W     = 16;
  localparam int QUAT_W    = 32;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int NORM_W    = 21;
  localparam int UP_W      = 19;
  localparam int VG_W      = 24;
  localparam int VM_W      = 28;

  localparam int NORM_LIM = 524288;
  localparam int UP_LIM   = 131072;
  localparam int VG_LIM   = 4194304;
  localparam int VM_LIM   = 67108864;
  localparam int ONE_Q16  = 65536;

  localparam int ACC_SHIFT = Q_FRAC - ACCEL_FRAC_BITS;
  localparam int UP_SHIFT  = 2 * QUAT_FRAC_BITS - 18;
  localparam int RAW_SH_W  = RAW_W + ACC_SHIFT;
  localparam int NSUM_W    = ((RAW_SH_W > CFG_W) ? RAW_SH_W : CFG_W) + 1;
  localparam int PROD_W    = 2 * QUAT_W;
  localparam int RND_W     = PROD_W - UP_SHIFT;
  localparam int UPRE_W    = RND_W + 1;
  localparam int DIFF_W    = NORM_W + 1;
  localparam int DP_W      = DIFF_W + UP_W;
  localparam int DOT_W     = DP_W + 2;
  localparam int VP_W      = VG_W + CFG_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_OFFSETS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_G_TO_MPS2   = 3'd4;

  localparam logic [CFG_W-1:0] G_TO_MPS2_RST = 20'd642688;

  // Pipeline stage positions
  localparam int ST_PROD = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_UP   = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_VG   = 4;
  localparam int ST_MPS  = 5;
  localparam int ST_OUT  = 6;
  localparam int NSTG    = 7;

endpackage

### design/quaternion_vertical_acceleration_core.sv
// Top level: pipelined gravity removal and vertical acceleration from an IMU sample.
`timescale 1ns / 1ps
// Takes one word per cycle while in_stall is low and returns one result word per
// input word, in order. The seven register stages are: accelerometer scaling with
// the six 32x32 quaternion products, the half-product sums, rounding and
// saturation of the up vector, the three dot product terms, the dot sum to
// vert_g, the m/s^2 product, and its rounding.
// A stall on the output only holds occupied stages; empty stages keep filling,
// so input is taken while a finished result waits. The configuration port is
// always ready; write it only while no word is in flight.
module quaternion_vertical_acceleration_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [qva_pkg::RAW_W-1:0]       in_raw_ax,
  input  logic signed [qva_pkg::RAW_W-1:0]       in_raw_ay,
  input  logic signed [qva_pkg::RAW_W-1:0]       in_raw_az,
  input  logic signed [qva_pkg::QUAT_W-1:0]      in_quat_w,
  input  logic signed [qva_pkg::QUAT_W-1:0]      in_quat_x,
  input  logic signed [qva_pkg::QUAT_W-1:0]      in_quat_y,
  input  logic signed [qva_pkg::QUAT_W-1:0]      in_quat_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qva_pkg::NORM_W-1:0]      out_norm_x,
  output logic signed [qva_pkg::NORM_W-1:0]      out_norm_y,
  output logic signed [qva_pkg::NORM_W-1:0]      out_norm_z,
  output logic signed [qva_pkg::UP_W-1:0]        out_up_x,
  output logic signed [qva_pkg::UP_W-1:0]        out_up_y,
  output logic signed [qva_pkg::UP_W-1:0]        out_up_z,
  output logic signed [qva_pkg::VG_W-1:0]        out_vert_g,
  output logic signed [qva_pkg::VM_W-1:0]        out_vert_mps2,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [qva_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [qva_pkg::CFG_W-1:0]              cfg_data
);
  import qva_pkg::*;

  localparam logic signed [NSUM_W-1:0]   NORM_HI = NSUM_W'(NORM_LIM);
  localparam logic signed [NSUM_W-1:0]   NORM_LO = -NORM_HI;
  localparam logic signed [UPRE_W-1:0]   UP_HI   = UPRE_W'(UP_LIM);
  localparam logic signed [UPRE_W-1:0]   UP_LO   = -UP_HI;
  localparam logic signed [UPRE_W-1:0]   UZ_ONE  = UPRE_W'(ONE_Q16);
  localparam logic signed [PROD_W-1:0]   UP_HALF = PROD_W'(1) <<< (UP_SHIFT - 1);
  localparam logic signed [DOT_W-1:0]    DOT_HALF = DOT_W'(1) <<< (Q_FRAC - 1);
  localparam logic signed [DOT_W-Q_FRAC-1:0] VG_HI = (DOT_W - Q_FRAC)'(VG_LIM);
  localparam logic signed [DOT_W-Q_FRAC-1:0] VG_LO = -VG_HI;
  localparam logic signed [VP_W-1:0]     VP_HALF = VP_W'(1) <<< (Q_FRAC - 1);
  localparam logic signed [VP_W-Q_FRAC-1:0]  VM_HI = (VP_W - Q_FRAC)'(VM_LIM);
  localparam logic signed [VP_W-Q_FRAC-1:0]  VM_LO = -VM_HI;

  // configuration registers
  logic signed [CFG_W-1:0] off_r [3];
  logic                    use_off_r;
  logic [CFG_W-1:0]        g_r;

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // stage payloads
  logic signed [NORM_W-1:0] norm_r [NSTG][3];
  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [PROD_W-1:0] hsum_r [3];
  logic signed [UP_W-1:0]   up_r [ST_UP:ST_OUT][3];
  logic signed [DP_W-1:0]   dp_r [3];
  logic signed [VG_W-1:0]   vg_r [ST_VG:ST_OUT];
  logic signed [VP_W-1:0]   vp_r;
  logic signed [VM_W-1:0]   vm_r;

  // combinational next values
  logic signed [RAW_W-1:0]        raw [3];
  logic signed [NSUM_W-1:0]       nsum [3];
  logic signed [NORM_W-1:0]       norm_nxt [3];
  logic signed [PROD_W-1:0]       prod_nxt [6];
  logic signed [PROD_W-1:0]       hsum_nxt [3];
  logic signed [PROD_W-1:0]       rsum [3];
  logic signed [UPRE_W-1:0]       upre [3];
  logic signed [UP_W-1:0]         up_nxt [3];
  logic signed [DIFF_W-1:0]       diff [3];
  logic signed [DP_W-1:0]         dp_nxt [3];
  logic signed [DOT_W-1:0]        dot;
  logic signed [DOT_W-Q_FRAC-1:0] vgw;
  logic signed [VG_W-1:0]         vg_nxt;
  logic signed [VP_W-1:0]         vp_nxt;
  logic signed [VP_W-1:0]         vpr;
  logic signed [VP_W-Q_FRAC-1:0]  vmw;
  logic signed [VM_W-1:0]         vm_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0]  <= '0;
      off_r[1]  <= '0;
      off_r[2]  <= '0;
      use_off_r <= 1'b1;
      g_r       <= G_TO_MPS2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OFFSET_X:    off_r[0]  <= cfg_data;
        CFG_OFFSET_Y:    off_r[1]  <= cfg_data;
        CFG_OFFSET_Z:    off_r[2]  <= cfg_data;
        CFG_USE_OFFSETS: use_off_r <= cfg_data[0];
        CFG_G_TO_MPS2:   g_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the one after it advances
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[ST_PROD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: accel scaling and quaternion products
  assign raw[0] = in_raw_ax;
  assign raw[1] = in_raw_ay;
  assign raw[2] = in_raw_az;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsum[i] = (NSUM_W'(raw[i]) <<< ACC_SHIFT)
              + (use_off_r ? NSUM_W'(off_r[i]) : NSUM_W'(0));
      if (nsum[i] > NORM_HI) begin
        norm_nxt[i] = NORM_W'(NORM_HI);
      end else if (nsum[i] < NORM_LO) begin
        norm_nxt[i] = NORM_W'(NORM_LO);
      end else begin
        norm_nxt[i] = NORM_W'(nsum[i]);
      end
    end
    prod_nxt[0] = PROD_W'(in_quat_x) * PROD_W'(in_quat_z);
    prod_nxt[1] = PROD_W'(in_quat_w) * PROD_W'(in_quat_y);
    prod_nxt[2] = PROD_W'(in_quat_y) * PROD_W'(in_quat_z);
    prod_nxt[3] = PROD_W'(in_quat_w) * PROD_W'(in_quat_x);
    prod_nxt[4] = PROD_W'(in_quat_w) * PROD_W'(in_quat_w);
    prod_nxt[5] = PROD_W'(in_quat_z) * PROD_W'(in_quat_z);
  end

  // stage 1: floored half products summed (differenced for x)
  always_comb begin
    hsum_nxt[0] = (prod_r[0] >>> 1) - (prod_r[1] >>> 1);
    hsum_nxt[1] = (prod_r[2] >>> 1) + (prod_r[3] >>> 1);
    hsum_nxt[2] = (prod_r[4] >>> 1) + (prod_r[5] >>> 1);
  end

  // stage 2: round to Q16, remove one from z, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = hsum_r[i] + UP_HALF;
      upre[i] = UPRE_W'($signed(rsum[i][PROD_W-1:UP_SHIFT]));
    end
    upre[2] = upre[2] - UZ_ONE;
    for (int i = 0; i < 3; i++) begin
      if (upre[i] > UP_HI) begin
        up_nxt[i] = UP_W'(UP_HI);
      end else if (upre[i] < UP_LO) begin
        up_nxt[i] = UP_W'(UP_LO);
      end else begin
        up_nxt[i] = UP_W'(upre[i]);
      end
    end
  end

  // stage 3: dot product terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = DIFF_W'(norm_r[ST_UP][i]) - DIFF_W'(up_r[ST_UP][i]);
      dp_nxt[i] = DP_W'(up_r[ST_UP][i]) * DP_W'(diff[i]);
    end
  end

  // stage 4: sum, round, saturate to g
  always_comb begin
    dot = DOT_W'(dp_r[0]) + DOT_W'(dp_r[1]) + DOT_W'(dp_r[2]) + DOT_HALF;
    vgw = $signed(dot[DOT_W-1:Q_FRAC]);
    if (vgw > VG_HI) begin
      vg_nxt = VG_W'(VG_HI);
    end else if (vgw < VG_LO) begin
      vg_nxt = VG_W'(VG_LO);
    end else begin
      vg_nxt = VG_W'(vgw);
    end
  end

  // stage 5: scale to m/s^2
  assign vp_nxt = VP_W'(vg_r[ST_VG]) * VP_W'($signed({1'b0, g_r}));

  // stage 6: round, saturate
  always_comb begin
    vpr = vp_r + VP_HALF;
    vmw = $signed(vpr[VP_W-1:Q_FRAC]);
    if (vmw > VM_HI) begin
      vm_nxt = VM_W'(VM_HI);
    end else if (vmw < VM_LO) begin
      vm_nxt = VM_W'(VM_LO);
    end else begin
      vm_nxt = VM_W'(vmw);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PROD]) begin
      norm_r[ST_PROD] <= norm_nxt;
      prod_r          <= prod_nxt;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        norm_r[k] <= norm_r[k-1];
      end
    end
    if (rdy[ST_SUM]) begin
      hsum_r <= hsum_nxt;
    end
    if (rdy[ST_UP]) begin
      up_r[ST_UP] <= up_nxt;
    end
    for (int k = ST_UP + 1; k <= ST_OUT; k++) begin
      if (rdy[k]) begin
        up_r[k] <= up_r[k-1];
      end
    end
    if (rdy[ST_MUL]) begin
      dp_r <= dp_nxt;
    end
    if (rdy[ST_VG]) begin
      vg_r[ST_VG] <= vg_nxt;
    end
    for (int k = ST_VG + 1; k <= ST_OUT; k++) begin
      if (rdy[k]) begin
        vg_r[k] <= vg_r[k-1];
      end
    end
    if (rdy[ST_MPS]) begin
      vp_r <= vp_nxt;
    end
    if (rdy[ST_OUT]) begin
      vm_r <= vm_nxt;
    end
  end

  assign out_valid     = vld_r[ST_OUT];
  assign out_norm_x    = norm_r[ST_OUT][0];
  assign out_norm_y    = norm_r[ST_OUT][1];
  assign out_norm_z    = norm_r[ST_OUT][2];
  assign out_up_x      = up_r[ST_OUT][0];
  assign out_up_y      = up_r[ST_OUT][1];
  assign out_up_z      = up_r[ST_OUT][2];
  assign out_vert_g    = vg_r[ST_OUT];
  assign out_vert_mps2 = vm_r;

endmodule

### verif/tb_quaternion_vertical_acceleration_core.sv
`timescale 1ns / 1ps
// Testbench: random and directed IMU words through the vertical acceleration core, checked in order.
module tb_quaternion_vertical_acceleration_core;
  import qva_pkg::*;

  typedef struct {
    logic signed [RAW_W-1:0]  ax, ay, az;
    logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  } imu_sample_t;

  typedef struct {
    logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
    logic signed [UP_W-1:0]   up_x, up_y, up_z;
    logic signed [VG_W-1:0]   vert_g;
    logic signed [VM_W-1:0]   vert_mps2;
  } vert_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [RAW_W-1:0]  in_raw_ax = '0, in_raw_ay = '0, in_raw_az = '0;
  logic signed [QUAT_W-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [NORM_W-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic signed [UP_W-1:0]   out_up_x, out_up_y, out_up_z;
  logic signed [VG_W-1:0]   out_vert_g;
  logic signed [VM_W-1:0]   out_vert_mps2;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  // register mirror
  longint off_x = 0, off_y = 0, off_z = 0;
  longint g_fac = longint'(G_TO_MPS2_RST);
  logic   use_off = 1'b1;

  imu_sample_t  pend_q[$];
  vert_result_t exp_q[$];
  imu_sample_t  cur;
  bit took = 1'b0, calm = 1'b0, hold_req = 1'b0, hold_started = 1'b0;
  int gap_left = 0, stall_left = 0, hold_left = 0, errors = 0;

  quaternion_vertical_acceleration_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint half_floor(longint p);
    return p >>> 1;
  endfunction

  function automatic longint round_q(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic vert_result_t predict_vertical(imu_sample_t s);
    longint ax, ay, az, qw, qx, qy, qz, ux, uy, uz, dot, vg, vm;
    vert_result_t r;
    ax = longint'(s.ax) <<< ACC_SHIFT;
    ay = longint'(s.ay) <<< ACC_SHIFT;
    az = longint'(s.az) <<< ACC_SHIFT;
    qw = longint'(s.qw);
    qx = longint'(s.qx);
    qy = longint'(s.qy);
    qz = longint'(s.qz);
    if (use_off) begin
      ax += off_x;
      ay += off_y;
      az += off_z;
    end
    ax = clip(ax, NORM_LIM);
    ay = clip(ay, NORM_LIM);
    az = clip(az, NORM_LIM);
    ux = clip(round_q(half_floor(qx * qz) - half_floor(qw * qy), UP_SHIFT), UP_LIM);
    uy = clip(round_q(half_floor(qy * qz) + half_floor(qw * qx), UP_SHIFT), UP_LIM);
    uz = clip(round_q(half_floor(qw * qw) + half_floor(qz * qz), UP_SHIFT) - ONE_Q16, UP_LIM);
    dot = ux * (ax - ux) + uy * (ay - uy) + uz * (az - uz);
    vg = clip(round_q(dot, Q_FRAC), VG_LIM);
    vm = clip(round_q(vg * g_fac, Q_FRAC), VM_LIM);
    r.norm_x    = ax[NORM_W-1:0];
    r.norm_y    = ay[NORM_W-1:0];
    r.norm_z    = az[NORM_W-1:0];
    r.up_x      = ux[UP_W-1:0];
    r.up_y      = uy[UP_W-1:0];
    r.up_z      = uz[UP_W-1:0];
    r.vert_g    = vg[VG_W-1:0];
    r.vert_mps2 = vm[VM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [RAW_W-1:0] raw_corner();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'sh2000;
    endcase
  endfunction

  function automatic logic signed [QUAT_W-1:0] quat_corner();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh4000_0000;
      3: return 32'shC000_0000;
      default: return 32'sh0000_0000;
    endcase
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic push_sample(logic signed [RAW_W-1:0] ax, logic signed [RAW_W-1:0] ay,
                             logic signed [RAW_W-1:0] az, logic signed [QUAT_W-1:0] qw,
                             logic signed [QUAT_W-1:0] qx, logic signed [QUAT_W-1:0] qy,
                             logic signed [QUAT_W-1:0] qz);
    imu_sample_t s;
    s.ax = ax; s.ay = ay; s.az = az;
    s.qw = qw; s.qx = qx; s.qy = qy; s.qz = qz;
    pend_q.push_back(s);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OFFSET_X:    off_x = longint'($signed(data));
      CFG_OFFSET_Y:    off_y = longint'($signed(data));
      CFG_OFFSET_Z:    off_z = longint'($signed(data));
      CFG_USE_OFFSETS: use_off = data[0];
      CFG_G_TO_MPS2:   g_fac = longint'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(int ox, int oy, int oz, logic off_en, int g);
    write_reg(CFG_OFFSET_X, CFG_W'(ox));
    write_reg(CFG_OFFSET_Y, CFG_W'(oy));
    write_reg(CFG_OFFSET_Z, CFG_W'(oz));
    write_reg(CFG_USE_OFFSETS, CFG_W'(off_en));
    write_reg(CFG_G_TO_MPS2, CFG_W'(g));
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (pend_q.size() != 0 || in_valid || exp_q.size() != 0);
  endtask

  function automatic int rand_offset();
    return int'($urandom_range(0, 524288)) - 262144;
  endfunction

  task automatic run_phase(int n);
    imu_sample_t s;
    real a, b, c, d, m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          s.ax = RAW_W'($urandom);
          s.ay = RAW_W'($urandom);
          s.az = RAW_W'($urandom);
        end
        2: begin
          // near rest, roughly 1 g on one axis
          s.ax = RAW_W'(int'($urandom_range(0, 2000)) - 1000);
          s.ay = RAW_W'(int'($urandom_range(0, 2000)) - 1000);
          s.az = RAW_W'(int'($urandom_range(0, 2000)) + 7192);
          if ($urandom_range(0, 1)) s.az = -s.az;
        end
        default: begin
          s.ax = raw_corner();
          s.ay = raw_corner();
          s.az = raw_corner();
        end
      endcase
      case ($urandom_range(0, 9))
        6, 7: begin
          s.qw = $urandom;
          s.qx = $urandom;
          s.qy = $urandom;
          s.qz = $urandom;
        end
        8: begin
          s.qw = quat_corner();
          s.qx = quat_corner();
          s.qy = quat_corner();
          s.qz = quat_corner();
        end
        9: begin
          s.qw = int'($urandom_range(0, 1 << 23)) - (1 << 22);
          s.qx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
          s.qy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
          s.qz = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        end
        default: begin
          // unit quaternion in Q30
          a = real'($urandom_range(0, 2000000)) - 1000000.0;
          b = real'($urandom_range(0, 2000000)) - 1000000.0;
          c = real'($urandom_range(0, 2000000)) - 1000000.0;
          d = real'($urandom_range(0, 2000000)) - 1000000.0;
          m = $sqrt(a * a + b * b + c * c + d * d);
          if (m < 1.0) m = 1.0;
          s.qw = $rtoi(a / m * 1073741824.0);
          s.qx = $rtoi(b / m * 1073741824.0);
          s.qy = $rtoi(c / m * 1073741824.0);
          s.qz = $rtoi(d / m * 1073741824.0);
        end
      endcase
      pend_q.push_back(s);
    end
    wait_drain();
  endtask

  // result checker and input acceptance
  always @(posedge clk) begin
    vert_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        e = exp_q.pop_front();
        check_field("norm_x", e.norm_x, out_norm_x);
        check_field("norm_y", e.norm_y, out_norm_y);
        check_field("norm_z", e.norm_z, out_norm_z);
        check_field("up_x", e.up_x, out_up_x);
        check_field("up_y", e.up_y, out_up_y);
        check_field("up_z", e.up_z, out_up_z);
        check_field("vert_g", e.vert_g, out_vert_g);
        check_field("vert_mps2", e.vert_mps2, out_vert_mps2);
      end
    end
    took = rst_n && in_valid && !in_stall;
    if (took) exp_q.push_back(predict_vertical(cur));
  end

  // sample driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(0, 8);
      end else if (pend_q.size() > 0) begin
        cur = pend_q.pop_front();
        in_valid  <= 1'b1;
        in_raw_ax <= cur.ax;
        in_raw_ay <= cur.ay;
        in_raw_az <= cur.az;
        in_quat_w <= cur.qw;
        in_quat_x <= cur.qx;
        in_quat_y <= cur.qy;
        in_quat_z <= cur.qz;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    push_sample(0, 0, 0, 0, 0, 0, 0);
    push_sample(0, 0, 8192, 32'sh4000_0000, 0, 0, 0);
    push_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh4000_0000, 0, 0, 0);
    push_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'sh4000_0000, 0, 0, 0);
    push_sample(0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_sample(16'sh7FFF, 16'sh8000, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF);
    push_sample(-8192, 0, 0, 32'shC000_0000, 0, 0, 0);
    push_sample(0, 0, -8192, 0, 32'sh4000_0000, 0, 0);
    push_sample(0, 8192, 0, 0, 0, 32'sh4000_0000, 32'sh4000_0000);
    // rounding ties on the up vector
    push_sample(0, 0, 0, 32'sh0020_0000, 0, 0, 0);
    push_sample(0, 0, 0, 32'sh0020_0000, 0, 32'sh0020_0000, 0);
    push_sample(0, 0, 0, 0, 0, 32'sh0020_0000, 32'sh0020_0000);
    // odd products halved toward minus infinity
    push_sample(1, -1, 1, 1, 1, 1, -1);
    push_sample(-1, 1, -1, -3, 3, -1, 1);
    push_sample(100, -100, 8192, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000);
    push_sample(16'sh5555, 16'shAAAA, 16'sh5555, 32'sh5555_5555, 32'shAAAA_AAAA,
                32'sh5555_5555, 32'shAAAA_AAAA);
    push_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                32'shAAAA_AAAA, 32'sh5555_5555);
    push_sample(5792, 0, 5792, 32'sd759250125, 32'sd759250125, 0, 0);
    push_sample(0, 8192, 0, 32'sd759250125, 0, 0, 32'sd759250125);
    wait_drain();

    // full-width offsets reach saturation; unused indexes must be ignored
    write_settings(524287, -524288, 262144, 1'b1, 1048575);
    for (int k = int'(CFG_G_TO_MPS2) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
    run_phase(197);

    write_settings(-262144, 262144, -1, 1'b0, 0);
    run_phase(197);

    write_settings(rand_offset(), rand_offset(), rand_offset(), 1'b1, $urandom_range(0, 1048575));
    hold_req = 1'b1;
    run_phase(197);

    write_settings(rand_offset(), rand_offset(), rand_offset(), 1'b1, G_TO_MPS2_RST);
    run_phase(197);

    write_settings(rand_offset(), rand_offset(), rand_offset(), 1'b0, $urandom_range(0, 1048575));
    run_phase(197);

    write_settings(rand_offset(), rand_offset(), rand_offset(), 1'b1, $urandom_range(0, 1048575));
    calm = 1'b1;
    run_phase(197);

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
